// ===== src/pcts_pkg.sv =====
// Shared constants, types and the front-to-back command format of the task scheduler.
package pcts_pkg;

  localparam int NUM_TASKS     = 32;
  localparam int PRIORITY_BITS = 8;
  localparam int TIDX_W        = $clog2(NUM_TASKS);
  localparam int CNT_W         = 9;
  localparam int IN_IDX_W      = 5;
  localparam int IN_PRI_W      = 8;
  localparam int Q_DEPTH       = 2;
  localparam int QPTR_W        = $clog2(Q_DEPTH);
  localparam int QCNT_W        = $clog2(Q_DEPTH + 1);
  localparam int SUM_W         = ((PRIORITY_BITS > CNT_W - 1) ? PRIORITY_BITS : CNT_W - 1) + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_LOAD,
    CMD_REPORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [TIDX_W-1:0]        idx;
    logic [PRIORITY_BITS-1:0] pri;
    logic [CNT_W-1:0]         cnt;
    logic                     run;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_SCAN,
    S_REFILL,
    S_FIN
  } state_t;

endpackage

// ===== src/pcts_front.sv =====
// Front end: takes input items, classifies them into commands and queues them for the back end.
module pcts_front import pcts_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic [IN_IDX_W-1:0] task_index,
  input  logic [IN_PRI_W-1:0] priority_value,
  input  logic [CNT_W-1:0]    counter_value,
  input  logic                runnable,
  output logic                q_valid,
  input  logic                q_ready,
  output cmd_t                q_cmd
);

  cmd_t              cls;
  cmd_t              qmem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] q_count;
  logic              push;
  logic              pop;
  logic              slot_ok;

  // loads to the idle slot or past the table only report state
  assign slot_ok = (task_index != '0) && ({{(32-IN_IDX_W){1'b0}}, task_index} < NUM_TASKS);

  always_comb begin
    cls.idx = TIDX_W'(task_index);
    cls.pri = PRIORITY_BITS'(priority_value);
    cls.cnt = counter_value;
    cls.run = runnable;
    if (!op) begin
      cls.kind = CMD_TICK;
    end else if (slot_ok) begin
      cls.kind = CMD_LOAD;
    end else begin
      cls.kind = CMD_REPORT;
    end
  end

  assign in_ready = (q_count != QCNT_W'(Q_DEPTH));
  assign q_valid  = (q_count != '0);
  assign q_cmd    = qmem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        q_count <= q_count + 1'b1;
      end else if (pop && !push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

endmodule

// ===== src/pcts_back.sv =====
// Back end: task table and the sequencer that runs loads, ticks, scans and refills.
module pcts_back import pcts_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  cmd_t                q_cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IN_IDX_W-1:0] current_task,
  output logic                switched,
  output logic [CNT_W-1:0]    selected_counter,
  output logic                refilled,
  output logic                no_runnable
);

  logic [CNT_W-1:0]         tcnt [NUM_TASKS];
  logic [PRIORITY_BITS-1:0] tpri [NUM_TASKS];
  logic                     trun [NUM_TASKS];

  state_t            st, st_next;
  logic [TIDX_W-1:0] cur, cur_next;
  logic [TIDX_W-1:0] idx, idx_next;
  logic [TIDX_W-1:0] best, best_next;
  logic [CNT_W-1:0]  best_cnt, best_cnt_next;
  logic              refill_done, refill_done_next;
  logic              sw_flag, sw_flag_next;
  logic              none_flag, none_flag_next;
  logic              out_valid_next;
  logic              load_out;

  logic [TIDX_W-1:0]        rd_addr;
  logic [CNT_W-1:0]         rc;
  logic                     rr;
  logic [PRIORITY_BITS-1:0] rp;
  logic                     we_all;
  logic                     we_cnt;
  logic [TIDX_W-1:0]        wa;
  logic [CNT_W-1:0]         wcnt;

  logic [CNT_W-1:0]  dec_val;
  logic              hit;
  logic [TIDX_W-1:0] nb;
  logic [CNT_W-1:0]  nbc;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  refill_val;

  // one table read port, steered by the sequencer
  assign rd_addr = (st == S_SCAN || st == S_REFILL) ? idx : cur;
  assign rc      = tcnt[rd_addr];
  assign rp      = tpri[rd_addr];
  assign rr      = trun[rd_addr];

  assign dec_val    = (rc != '0) ? rc - 1'b1 : '0;
  assign hit        = rr && (rc > best_cnt);
  assign nb         = hit ? idx : best;
  assign nbc        = hit ? rc : best_cnt;
  assign sum        = SUM_W'(rc >> 1) + SUM_W'(rp);
  assign refill_val = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        tcnt[i] <= '0;
        tpri[i] <= '0;
        trun[i] <= 1'b0;
      end
    end else if (we_all) begin
      tcnt[wa] <= wcnt;
      tpri[wa] <= q_cmd.pri;
      trun[wa] <= q_cmd.run;
    end else if (we_cnt) begin
      tcnt[wa] <= wcnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      cur         <= '0;
      idx         <= '0;
      best        <= '0;
      best_cnt    <= '0;
      refill_done <= 1'b0;
      sw_flag     <= 1'b0;
      none_flag   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      st          <= st_next;
      cur         <= cur_next;
      idx         <= idx_next;
      best        <= best_next;
      best_cnt    <= best_cnt_next;
      refill_done <= refill_done_next;
      sw_flag     <= sw_flag_next;
      none_flag   <= none_flag_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      current_task     <= IN_IDX_W'(cur);
      switched         <= sw_flag;
      selected_counter <= rc;
      refilled         <= refill_done;
      no_runnable      <= none_flag;
    end
  end

  always_comb begin
    st_next          = st;
    cur_next         = cur;
    idx_next         = idx;
    best_next        = best;
    best_cnt_next    = best_cnt;
    refill_done_next = refill_done;
    sw_flag_next     = sw_flag;
    none_flag_next   = none_flag;
    out_valid_next   = out_valid && !out_ready;
    load_out         = 1'b0;
    q_ready          = 1'b0;
    we_all           = 1'b0;
    we_cnt           = 1'b0;
    wa               = cur;
    wcnt             = q_cmd.cnt;

    case (st)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          refill_done_next = 1'b0;
          sw_flag_next     = 1'b0;
          none_flag_next   = 1'b0;
          case (q_cmd.kind)
            CMD_LOAD: begin
              we_all  = 1'b1;
              wa      = q_cmd.idx;
              st_next = S_FIN;
            end
            CMD_TICK: begin
              if (cur == '0) begin
                idx_next      = TIDX_W'(NUM_TASKS - 1);
                best_next     = '0;
                best_cnt_next = '0;
                st_next       = S_SCAN;
              end else begin
                st_next = S_DEC;
              end
            end
            default: st_next = S_FIN;
          endcase
        end
      end
      S_DEC: begin
        we_cnt = 1'b1;
        wa     = cur;
        wcnt   = dec_val;
        if (dec_val == '0) begin
          idx_next      = TIDX_W'(NUM_TASKS - 1);
          best_next     = '0;
          best_cnt_next = '0;
          st_next       = S_SCAN;
        end else begin
          st_next = S_FIN;
        end
      end
      S_SCAN: begin
        // walk from the top slot down to 1; strict > keeps the higher index on ties
        if (idx == TIDX_W'(1)) begin
          if (nb == '0) begin
            if (!refill_done) begin
              refill_done_next = 1'b1;
              idx_next         = TIDX_W'(1);
              st_next          = S_REFILL;
            end else begin
              none_flag_next = 1'b1;
              st_next        = S_FIN;
            end
          end else begin
            sw_flag_next = (nb != cur);
            cur_next     = nb;
            st_next      = S_FIN;
          end
        end else begin
          idx_next      = idx - 1'b1;
          best_next     = nb;
          best_cnt_next = nbc;
        end
      end
      S_REFILL: begin
        we_cnt = rr;
        wa     = idx;
        wcnt   = refill_val;
        if (idx == TIDX_W'(NUM_TASKS - 1)) begin
          best_next     = '0;
          best_cnt_next = '0;
          st_next       = S_SCAN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          st_next        = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (st == S_FIN && out_valid && !out_ready) |=> (st == S_FIN))
    else $error("result slot overwritten while pending");
  a_sw_none: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(switched && no_runnable))
    else $error("switch reported together with no runnable task");
  a_sw_not_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && switched) |-> (current_task != '0))
    else $error("switch to the idle slot");
  a_refill_once: assert property (@(posedge clk) disable iff (rst)
    (st == S_REFILL) |-> refill_done)
    else $error("refill pass without refill mark");
`endif

endmodule

// ===== src/priority_counter_task_scheduler.sv =====
// Top level of the counter/priority timer-tick task scheduler.
// Sequence, transfer to result: a load writes its table slot; a tick decrements the current
// task's counter and, when it reaches zero or the idle task is current, scans the slots. With no
// runnable positive counter it adds a refill pass and a second scan before the result is posted.
// Throughput: one item at a time in the back end; a 2-deep queue keeps the input transferring.
// Reset (synchronous): all counters, priorities and runnable flags zero, idle task current.
module priority_counter_task_scheduler import pcts_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic [IN_IDX_W-1:0] task_index,
  input  logic [IN_PRI_W-1:0] priority_value,
  input  logic [CNT_W-1:0]    counter_value,
  input  logic                runnable,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IN_IDX_W-1:0] current_task,
  output logic                switched,
  output logic [CNT_W-1:0]    selected_counter,
  output logic                refilled,
  output logic                no_runnable
);

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  pcts_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .task_index     (task_index),
    .priority_value (priority_value),
    .counter_value  (counter_value),
    .runnable       (runnable),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_cmd          (q_cmd)
  );

  pcts_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_cmd            (q_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .current_task     (current_task),
    .switched         (switched),
    .selected_counter (selected_counter),
    .refilled         (refilled),
    .no_runnable      (no_runnable)
  );

endmodule
